/* hdl/vfv_pkg.sv */
`default_nettype none

package vfv_pkg;

    // fixed field widths of the stream and configuration ports
    localparam int COORD_W    = 4;
    localparam int IN_TYPE_W  = 8;
    localparam int OUT_TYPE_W = 8;
    localparam int ORG_W      = 24;
    localparam int WORLD_W    = 25;
    localparam int VTX_W      = 17;
    localparam int FACES      = 6;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_IDX_W  = 2;

    localparam logic [VTX_W-1:0] VTX_STEP = 17'd4;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_PLACE = 2'd0,
        KIND_BREAK = 2'd1,
        KIND_START = 2'd2,
        KIND_MESH  = 2'd3
    } t_kind;

    // face directions
    localparam logic [2:0] DIR_NORTH  = 3'd0;
    localparam logic [2:0] DIR_SOUTH  = 3'd1;
    localparam logic [2:0] DIR_EAST   = 3'd2;
    localparam logic [2:0] DIR_WEST   = 3'd3;
    localparam logic [2:0] DIR_TOP    = 3'd4;
    localparam logic [2:0] DIR_BOTTOM = 3'd5;
    localparam logic [2:0] DIR_COUNT  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // latch an accepted item
        logic       clr_wr;     // write one entry of the clearing pass
        logic       nb_rd;      // read the neighbour in direction dir
        logic       nb_wb;      // update the neighbour read in the previous cycle
        logic       own_wr;     // write the item's own cell
        logic       own_rd;     // read the item's own cell
        logic       mesh_load;  // take the own cell read data as face mask
        logic       emit;       // hand faces to the output register
        logic [2:0] dir;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        t_kind kind;        // kind of the item on the input port
        logic  in_grid;     // its cell lies inside the grid
        logic  clr_last;    // clearing pass at its final entry
        logic  mesh_hit;    // own cell is solid with a visible face
        logic  emit_done;   // final face goes out this cycle
    } t_stat;

endpackage

`default_nettype wire

/* hdl/vfv_ctrl.sv */
`default_nettype none

module vfv_ctrl
    import vfv_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_axis_tvalid,
    output logic  o_s_axis_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_NB    = 7'b0000100,
        S_OWN   = 7'b0001000,
        S_MRD   = 7'b0010000,
        S_MCHK  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.dir = r_step;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    unique case (i_stat.kind)
                        KIND_PLACE, KIND_BREAK: n_state = i_stat.in_grid ? S_NB : S_IDLE;
                        KIND_MESH:              n_state = i_stat.in_grid ? S_MRD : S_IDLE;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_NB: begin
                // read neighbour step while updating neighbour step-1
                o_cmd.nb_rd = (r_step != DIR_COUNT);
                o_cmd.nb_wb = (r_step != '0);
                if (r_step == DIR_COUNT) begin
                    n_state = S_OWN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_OWN: begin
                o_cmd.own_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_MRD: begin
                o_cmd.own_rd = 1'b1;
                n_state      = S_MCHK;
            end
            S_MCHK: begin
                o_cmd.mesh_load = 1'b1;
                n_state         = i_stat.mesh_hit ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

/* hdl/vfv_datapath.sv */
`default_nettype none

module vfv_datapath
    import vfv_pkg::*;
#(
    parameter int GRID_EDGE = 16,
    parameter int TYPE_BITS = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    // accepted item fields
    input  wire  [1:0]             i_kind,
    input  wire  [IN_TYPE_W-1:0]   i_block_type,
    input  wire  [COORD_W-1:0]     i_cell_x,
    input  wire  [COORD_W-1:0]     i_cell_y,
    input  wire  [COORD_W-1:0]     i_cell_z,
    // configuration writes
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [ORG_W-1:0]       i_cfg_data,
    // result channel
    input  wire                    i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int CW    = $clog2(GRID_EDGE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int WW    = TYPE_BITS + FACES;

    // cell store: visible bits over block type
    logic [WW-1:0]        r_mem [DEPTH];
    logic [WW-1:0]        r_rd_word;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WW-1:0]        mem_wdata;

    logic [AW-1:0]        r_clr_addr;
    logic [CW-1:0]        r_x, r_y, r_z;
    logic [TYPE_BITS-1:0] r_type;
    logic                 r_place;
    logic [FACES-1:0]     r_acc;
    logic                 r_rd_ok;
    logic [2:0]           r_wb_dir;
    // address of the neighbour read in the previous cycle
    logic [AW-1:0]        r_wb_addr;
    logic [FACES-1:0]     r_mask;
    logic [TYPE_BITS-1:0] r_mtype;
    logic [VTX_W-1:0]     r_vcnt;
    logic signed [ORG_W-1:0] r_org_x, r_org_y, r_org_z;

    logic                 r_m_valid;
    logic [2:0]           r_o_dir;
    logic [OUT_TYPE_W-1:0] r_o_type;
    logic [WORLD_W-1:0]   r_o_wx, r_o_wy, r_o_wz;
    logic [VTX_W-1:0]     r_o_base;
    logic                 r_o_last;

    logic [TYPE_BITS-1:0] in_type;
    logic                 in_solid;
    logic [CW-1:0]        nx, ny, nz;
    logic                 nb_ok;
    logic [AW-1:0]        own_addr;
    logic [TYPE_BITS-1:0] rd_type;
    logic [FACES-1:0]     rd_vis;
    logic [FACES-1:0]     opp_bit;
    logic [FACES-1:0]     nb_vis;
    logic [2:0]           lo_dir;
    logic [FACES-1:0]     rest_mask;
    logic                 out_free;
    logic                 emit_fire;

    // input decode
    assign in_type  = TYPE_BITS'(i_block_type);
    assign in_solid = (in_type != '0);

    assign o_stat.kind     = t_kind'(i_kind);
    assign o_stat.in_grid  = (32'(i_cell_x) < GRID_EDGE) && (32'(i_cell_y) < GRID_EDGE)
                             && (32'(i_cell_z) < GRID_EDGE);
    assign o_stat.clr_last = (&r_clr_addr);

    assign own_addr = {r_z, r_y, r_x};
    assign rd_type  = r_rd_word[TYPE_BITS-1:0];
    assign rd_vis   = r_rd_word[WW-1:TYPE_BITS];
    assign o_stat.mesh_hit = (rd_type != '0) && (rd_vis != '0);

    // neighbour cell and its bounds check
    always_comb begin
        nx    = r_x;
        ny    = r_y;
        nz    = r_z;
        nb_ok = 1'b0;
        unique case (i_cmd.dir)
            DIR_NORTH: begin
                nz    = r_z - 1'b1;
                nb_ok = (r_z != '0);
            end
            DIR_SOUTH: begin
                nz    = r_z + 1'b1;
                nb_ok = (32'(r_z) != GRID_EDGE - 1);
            end
            DIR_EAST: begin
                nx    = r_x + 1'b1;
                nb_ok = (32'(r_x) != GRID_EDGE - 1);
            end
            DIR_WEST: begin
                nx    = r_x - 1'b1;
                nb_ok = (r_x != '0);
            end
            DIR_TOP: begin
                ny    = r_y + 1'b1;
                nb_ok = (32'(r_y) != GRID_EDGE - 1);
            end
            DIR_BOTTOM: begin
                ny    = r_y - 1'b1;
                nb_ok = (r_y != '0);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // neighbour update: the face pointing back at the item's cell
    assign opp_bit = FACES'(1) << (r_wb_dir ^ 3'd1);
    assign nb_vis  = r_place ? (rd_vis & ~opp_bit) : (rd_vis | opp_bit);

    // store port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = own_addr;
        mem_wdata = {r_acc, r_type};
        priority if (i_cmd.clr_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = {{FACES{1'b1}}, {TYPE_BITS{1'b0}}};
        end else if (i_cmd.nb_wb && r_rd_ok) begin
            mem_we    = 1'b1;
            mem_waddr = r_wb_addr;
            mem_wdata = {nb_vis, rd_type};
        end else if (i_cmd.own_wr) begin
            mem_we    = 1'b1;
        end else begin
            mem_we    = 1'b0;
        end
    end

    assign mem_re    = i_cmd.nb_rd || i_cmd.own_rd;
    assign mem_raddr = i_cmd.own_rd ? own_addr : {nz, ny, nx};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_word <= r_mem[mem_raddr];
        end
    end

    // item registers and culling accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= CW'(i_cell_x);
            r_y     <= CW'(i_cell_y);
            r_z     <= CW'(i_cell_z);
            r_place <= (t_kind'(i_kind) == KIND_PLACE) && in_solid;
            r_type  <= ((t_kind'(i_kind) == KIND_PLACE) && in_solid) ? in_type : '0;
            r_acc   <= '1;
        end else if (i_cmd.nb_wb && r_rd_ok && r_place && (rd_type != '0)) begin
            r_acc[r_wb_dir] <= 1'b0;
        end
        if (i_cmd.nb_rd) begin
            r_rd_ok   <= nb_ok;
            r_wb_dir  <= i_cmd.dir;
            r_wb_addr <= {nz, ny, nx};
        end
        if (i_cmd.mesh_load) begin
            r_mask  <= rd_vis;
            r_mtype <= rd_type;
        end else if (emit_fire) begin
            r_mask  <= rest_mask;
        end
    end

    // lowest visible face still to go
    always_comb begin
        logic found;
        found  = 1'b0;
        lo_dir = '0;
        for (int i = 0; i < FACES; i++) begin
            if (!found && r_mask[i]) begin
                lo_dir = 3'(i);
                found  = 1'b1;
            end
        end
    end

    assign rest_mask        = r_mask & ~(FACES'(1) << lo_dir);
    assign out_free         = !r_m_valid || i_m_tready;
    assign emit_fire        = i_cmd.emit && out_free;
    assign o_stat.emit_done = emit_fire && (rest_mask == '0);

    // control registers: clear pointer, vertex counter, origin, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_vcnt     <= '0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_org_z    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load && (t_kind'(i_kind) == KIND_START)) begin
                r_vcnt <= '0;
            end else if (emit_fire) begin
                r_vcnt <= r_vcnt + VTX_STEP;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                    CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                    CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (emit_fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_o_dir  <= lo_dir;
            r_o_type <= OUT_TYPE_W'(r_mtype);
            r_o_wx   <= WORLD_W'(r_org_x) + WORLD_W'(r_x);
            r_o_wy   <= WORLD_W'(r_org_y) + WORLD_W'(r_y);
            r_o_wz   <= WORLD_W'(r_org_z) + WORLD_W'(r_z);
            r_o_base <= r_vcnt;
            r_o_last <= (rest_mask == '0);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {1'b0, r_o_base, r_o_wz, r_o_wy, r_o_wx, r_o_type, r_o_dir};

endmodule

`default_nettype wire

/* hdl/voxel_face_visibility_mesher.sv */
// channel   direction  handshake                        payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser kind, tdata item fields
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata face fields, tlast last face
// cfg       in         i_cfg_we (no wait)               i_cfg_idx, i_cfg_data
//
// place and break: accept, seven steps through the single cell store
// (neighbour reads overlapped with neighbour writes), then the own cell write
// mesh one cell: own read, mask check, then one face per cycle while the sink is ready
// start mesh and cells outside the grid return to idle at acceptance
// after reset a clearing pass over all 2**(3*clog2(GRID_EDGE)) entries (4096 by default)
// sets every cell to air with all faces visible; no item is taken meanwhile
// a finished face waits in the output register; a stalled sink holds emission

`default_nettype none

module voxel_face_visibility_mesher
    import vfv_pkg::*;
#(
    parameter int GRID_EDGE = 16,
    parameter int TYPE_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // block_type[7:0], cell_x[11:8], cell_y[15:12], cell_z[19:16], zero fill
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind[1:0]
    input  wire  [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // face_dir[2:0], face_type[10:3], world_x[35:11], world_y[60:36],
    // world_z[85:61], base_vertex[102:86], zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // last_face
    output logic                  o_m_axis_tlast,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [ORG_W-1:0]      i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    vfv_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // cell store, counters and output register
    vfv_datapath #(
        .GRID_EDGE (GRID_EDGE),
        .TYPE_BITS (TYPE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_s_axis_tuser),
        .i_block_type (i_s_axis_tdata[7:0]),
        .i_cell_x     (i_s_axis_tdata[11:8]),
        .i_cell_y     (i_s_axis_tdata[15:12]),
        .i_cell_z     (i_s_axis_tdata[19:16]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tvalid   (o_m_axis_tvalid),
        .o_m_tdata    (o_m_axis_tdata),
        .o_m_tlast    (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
